// ----- rtl/msst_pkg.sv -----
// shared constants, types and control structs of the timer slot engine
package msst_pkg;

  localparam int TimerSlots = 16;
  localparam int MaxResults = 16;
  localparam int SlotW      = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam int OpW    = 2;
  localparam int IdW    = 4;
  localparam int TicksW = 32;

  localparam logic [OpW-1:0] OP_START = 2'd0;
  localparam logic [OpW-1:0] OP_STOP  = 2'd1;
  localparam logic [OpW-1:0] OP_TICK  = 2'd2;

  typedef logic [SlotW-1:0]  slot_idx_t;
  typedef logic [CntW-1:0]   fire_cnt_t;
  typedef logic [TicksW-1:0] ticks_t;

  // controller to datapath
  typedef struct packed {
    logic      in_ready;
    logic      scan_step;
    logic      flush;
    slot_idx_t idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_req;
    logic due;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/msst_if.sv -----
// request and result channel interfaces of the timer slot engine
interface msst_in_if;
  logic                       valid;
  logic                       ready;
  logic [msst_pkg::OpW-1:0]   operation;
  logic [msst_pkg::IdW-1:0]   slot_id;
  logic [msst_pkg::TicksW-1:0] period_ticks;
  logic [msst_pkg::TicksW-1:0] repeat_count;
  logic                       reload_mode;
  logic [msst_pkg::TicksW-1:0] first_delay;

  modport source (output valid, operation, slot_id, period_ticks, repeat_count,
                  reload_mode, first_delay, input ready);
  modport sink   (input valid, operation, slot_id, period_ticks, repeat_count,
                  reload_mode, first_delay, output ready);
endinterface

interface msst_out_if;
  logic                     valid;
  logic                     ready;
  logic [msst_pkg::IdW-1:0] fired_slot;
  logic                     expired;
  logic                     last;

  modport source (output valid, fired_slot, expired, last, input ready);
  modport sink   (input valid, fired_slot, expired, last, output ready);
endinterface

// ----- rtl/msst_ctrl.sv -----
// controller: idle, slot scan and final result flush sequencing
module msst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msst_pkg::status_t status_i,
  output msst_pkg::cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]          state_q, state_d;
  msst_pkg::slot_idx_t idx_q, idx_d;
  logic                step_ok;

  assign step_ok = !(status_i.due && status_i.pend_valid && !status_i.out_free);

  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    cmd_o.in_ready  = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.flush     = 1'b0;
    cmd_o.idx       = idx_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.tick_req) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (step_ok) begin
          cmd_o.scan_step = 1'b1;
          if (idx_q == msst_pkg::slot_idx_t'(msst_pkg::TimerSlots - 1)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- rtl/msst_dp.sv -----
// datapath: tick counter, slot tables, pending result and output register
module msst_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msst_pkg::cmd_t    cmd_i,
  output msst_pkg::status_t status_o,
  msst_in_if.sink           in_i,
  msst_out_if.source        out_o
);

  msst_pkg::ticks_t    now_q;
  logic [msst_pkg::TimerSlots-1:0] active_q;
  msst_pkg::ticks_t    deadline_q  [msst_pkg::TimerSlots];
  msst_pkg::ticks_t    period_q    [msst_pkg::TimerSlots];
  msst_pkg::ticks_t    remaining_q [msst_pkg::TimerSlots];
  logic                mode_q      [msst_pkg::TimerSlots];
  msst_pkg::fire_cnt_t fire_cnt_q;

  logic                     pend_valid_q;
  logic [msst_pkg::IdW-1:0] pend_slot_q;
  logic                     pend_exp_q;

  logic                     out_valid_q;
  logic [msst_pkg::IdW-1:0] out_slot_q;
  logic                     out_exp_q;
  logic                     out_last_q;

  logic                accept;
  logic                slot_ok;
  msst_pkg::slot_idx_t wr_idx;
  msst_pkg::slot_idx_t idx;
  msst_pkg::ticks_t    rd_dl, rd_per, rd_rem, diff, eff_per, base, next_dl;
  logic                rd_mode, due, fire, exp_hit, out_free, push_pend;

  assign accept  = in_i.valid && cmd_i.in_ready;
  assign slot_ok = (32'(in_i.slot_id) < msst_pkg::TimerSlots);
  assign wr_idx  = msst_pkg::slot_idx_t'(in_i.slot_id);
  assign idx     = cmd_i.idx;

  assign rd_dl   = deadline_q[idx];
  assign rd_per  = period_q[idx];
  assign rd_rem  = remaining_q[idx];
  assign rd_mode = mode_q[idx];

  // wrap-safe due check
  assign diff    = now_q - rd_dl;
  assign due     = active_q[idx] && !diff[msst_pkg::TicksW-1]
                   && (fire_cnt_q < msst_pkg::fire_cnt_t'(msst_pkg::MaxResults));
  assign eff_per = (rd_per == '0) ? msst_pkg::ticks_t'(1) : rd_per;
  assign base    = rd_mode ? rd_dl : now_q;
  assign next_dl = base + eff_per;
  assign exp_hit = (rd_rem == msst_pkg::ticks_t'(1));
  assign fire    = cmd_i.scan_step && due;

  assign out_free  = !out_valid_q || out_o.ready;
  assign push_pend = (fire && pend_valid_q) || cmd_i.flush;

  assign status_o.tick_req   = in_i.valid && (in_i.operation == msst_pkg::OP_TICK);
  assign status_o.due        = due;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;

  assign in_i.ready       = cmd_i.in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.fired_slot = out_slot_q;
  assign out_o.expired    = out_exp_q;
  assign out_o.last       = out_last_q;

  // slot tables
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.operation == msst_pkg::OP_START) && slot_ok) begin
      period_q[wr_idx]    <= in_i.period_ticks;
      remaining_q[wr_idx] <= in_i.repeat_count;
      mode_q[wr_idx]      <= in_i.reload_mode;
      deadline_q[wr_idx]  <= now_q + in_i.first_delay;
    end else if (fire) begin
      if (rd_rem != '0) begin
        remaining_q[idx] <= rd_rem - 1'b1;
      end
      if (!exp_hit) begin
        deadline_q[idx] <= next_dl;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      active_q     <= '0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        case (in_i.operation)
          msst_pkg::OP_START: begin
            if (slot_ok) begin
              active_q[wr_idx] <= 1'b1;
            end
          end
          msst_pkg::OP_STOP: begin
            if (slot_ok) begin
              active_q[wr_idx] <= 1'b0;
            end
          end
          msst_pkg::OP_TICK: begin
            now_q      <= now_q + 1'b1;
            fire_cnt_q <= '0;
          end
          default: begin
          end
        endcase
      end
      if (fire) begin
        fire_cnt_q   <= fire_cnt_q + 1'b1;
        pend_valid_q <= 1'b1;
        if (exp_hit) begin
          active_q[idx] <= 1'b0;
        end
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (push_pend) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pending and output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_slot_q <= msst_pkg::IdW'(idx);
      pend_exp_q  <= exp_hit;
    end
    if (push_pend) begin
      out_slot_q <= pend_slot_q;
      out_exp_q  <= pend_exp_q;
      out_last_q <= cmd_i.flush;
    end
  end

endmodule

// ----- rtl/multi_slot_software_timer_engine_top.sv -----
// top level of the multi-slot timer engine
// requests enter on in_i (valid/ready): start arms a slot, stop disarms it,
// tick advances the 32-bit tick counter and scans every slot once.
// start, stop and unused codes produce no result.
// a tick is accepted, then the scan visits every slot in turn, then the final
// result is flushed if one is pending; the scan reads one slot table entry
// per cycle while the output does not stall it.
// each firing slot yields one result on out_o with fired_slot, expired and
// last; last marks the final result of that tick. results go through a
// one-entry pending stage and an output register: a result leaves the
// pending stage when the next firing slot is scanned or at the flush, and
// shows on out_o the cycle after.
// no new request is taken while a tick scan is in progress.
// when out_o stalls the scan pauses at the next firing slot until the output
// register frees up; no result is dropped or repeated.
// reset clears the tick counter and all slot active bits at once; slot
// tables need no clearing since they are read only for armed slots.
module multi_slot_software_timer_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  msst_in_if.sink    in_i,
  msst_out_if.source out_o
);

  msst_pkg::cmd_t    cmd;
  msst_pkg::status_t status;

  msst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  msst_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule
